// ===== rtl/sdly_pkg.sv =====
// Shared types, constants and helpers for the stereo delay effect.
`timescale 1ns / 1ps
package sdly_pkg;

  localparam int SAMPLE_BITS = 24;
  localparam int GAIN_W      = 16;
  localparam int BASE_W      = 17;
  localparam int RATIO_W     = 17;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 17;
  localparam int Q_ONE       = 32768;
  localparam int PROD_W      = SAMPLE_BITS + GAIN_W + 1;
  localparam int OUT_DEPTH   = 4;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic [GAIN_W-1:0]             gain_t;
  typedef logic signed [PROD_W-1:0]      prod_t;

  localparam gain_t GAIN_ONE   = gain_t'(Q_ONE);
  localparam gain_t WET_RESET  = gain_t'(Q_ONE / 2);

  typedef enum logic [1:0] {
    MODE_NORMAL,
    MODE_TAP,
    MODE_TAP_FB,
    MODE_PONG
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE,
    CFG_BASE,
    CFG_RATIO,
    CFG_FB,
    CFG_WET
  } cfg_idx_t;

  typedef struct packed {
    mode_t mode;
    gain_t fb;
    gain_t wet;
    gain_t dry;
  } sdly_set_t;

  typedef struct packed {
    logic take;
    logic wrapped;
  } sdly_item_t;

  function automatic sample_t sat_sample(input logic signed [31:0] v);
    logic signed [31:0] hi;
    logic signed [31:0] lo;
    hi = (32'sd1 <<< (SAMPLE_BITS - 1)) - 32'sd1;
    lo = -hi - 32'sd1;
    if (v > hi) begin
      return sample_t'(hi);
    end else if (v < lo) begin
      return sample_t'(lo);
    end
    return sample_t'(v);
  endfunction

  function automatic gain_t clamp_gain(input gain_t g);
    return (g > GAIN_ONE) ? GAIN_ONE : g;
  endfunction

endpackage

// ===== rtl/sdly_if.sv =====
// Channel interfaces: sample input, mixed output and register writes.
`timescale 1ns / 1ps
interface sdly_in_if;
  import sdly_pkg::*;
  logic    valid;
  logic    ready;
  sample_t left_in;
  sample_t right_in;
  modport source (output valid, left_in, right_in, input ready);
  modport sink (input valid, left_in, right_in, output ready);
endinterface

interface sdly_out_if;
  import sdly_pkg::*;
  logic    valid;
  logic    ready;
  sample_t left_out;
  sample_t right_out;
  modport source (output valid, left_out, right_out, input ready);
  modport sink (input valid, left_out, right_out, output ready);
endinterface

interface sdly_cfg_if;
  import sdly_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/stereo_delay_effect_top.sv =====
// A result passes lane stages s0 to s3 and the output queue before it is offered.
// Input: busy refuses a pair right after each take; each lane's delay line has one
//   read port, used for the main tap and then the second tap of every item.
// Reset (rst, synchronous): registers return to defaults, write position and
//   line fill state clear at once; unwritten positions read as zero, no sweep.
`timescale 1ns / 1ps
module stereo_delay_effect_top #(
  parameter int LINE_DEPTH = 131072
) (
  input  logic       clk,
  input  logic       rst,
  sdly_in_if.sink    in_ch,
  sdly_out_if.source out_ch,
  sdly_cfg_if.sink   cfg
);
  import sdly_pkg::*;

  localparam int AW = $clog2(LINE_DEPTH);

  sdly_set_t     set;
  logic [AW-1:0] dmain_l;
  logic [AW-1:0] dmain_r;
  logic [AW-1:0] dtap_l;
  logic [AW-1:0] dtap_r;

  logic          busy;
  logic          room;
  logic          take;
  logic [AW-1:0] wp;
  logic          wrapped;
  sdly_item_t    item;

  sample_t       main_l;
  sample_t       main_r;
  sample_t       res_l;
  sample_t       res_r;
  logic          res_valid_l;
  logic          res_valid_r;

  assign in_ch.ready = !busy && room;
  assign take        = in_ch.valid && in_ch.ready;
  assign item        = '{take: take, wrapped: wrapped};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b0;
      wp      <= '0;
      wrapped <= 1'b0;
    end else begin
      busy <= take;
      if (take) begin
        if (wp == AW'(LINE_DEPTH - 1)) begin
          wp      <= '0;
          wrapped <= 1'b1;
        end else begin
          wp <= wp + AW'(1);
        end
      end
    end
  end

  sdly_cfg #(.LINE_DEPTH(LINE_DEPTH)) u_cfg (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .set     (set),
    .dmain_l (dmain_l),
    .dmain_r (dmain_r),
    .dtap_l  (dtap_l),
    .dtap_r  (dtap_r)
  );

  sdly_lane #(.LINE_DEPTH(LINE_DEPTH)) u_lane_l (
    .clk        (clk),
    .rst        (rst),
    .set        (set),
    .dmain      (dmain_l),
    .dtap       (dtap_l),
    .item       (item),
    .item_wp    (wp),
    .x_own      (in_ch.left_in),
    .x_other    (in_ch.right_in),
    .peer_main  (main_r),
    .main_val   (main_l),
    .res_valid  (res_valid_l),
    .res_sample (res_l)
  );

  sdly_lane #(.LINE_DEPTH(LINE_DEPTH)) u_lane_r (
    .clk        (clk),
    .rst        (rst),
    .set        (set),
    .dmain      (dmain_r),
    .dtap       (dtap_r),
    .item       (item),
    .item_wp    (wp),
    .x_own      (in_ch.right_in),
    .x_other    (in_ch.left_in),
    .peer_main  (main_l),
    .main_val   (main_r),
    .res_valid  (res_valid_r),
    .res_sample (res_r)
  );

  sdly_merge u_merge (
    .clk   (clk),
    .rst   (rst),
    .take  (take),
    .push  (res_valid_l && res_valid_r),
    .left  (res_l),
    .right (res_r),
    .room  (room),
    .out   (out_ch)
  );

endmodule

// ===== rtl/sdly_cfg.sv =====
// Register file and delay length calculation.
`timescale 1ns / 1ps
module sdly_cfg #(
  parameter int LINE_DEPTH = 131072
) (
  input  logic                          clk,
  input  logic                          rst,
  sdly_cfg_if.sink                      cfg,
  output sdly_pkg::sdly_set_t           set,
  output logic [$clog2(LINE_DEPTH)-1:0] dmain_l,
  output logic [$clog2(LINE_DEPTH)-1:0] dmain_r,
  output logic [$clog2(LINE_DEPTH)-1:0] dtap_l,
  output logic [$clog2(LINE_DEPTH)-1:0] dtap_r
);
  import sdly_pkg::*;

  localparam int AW = $clog2(LINE_DEPTH);
  localparam int PW = GAIN_W + BASE_W;
  localparam logic [31:0] DMAX = 32'(LINE_DEPTH - 1);
  localparam logic signed [RATIO_W-1:0] R_ONE  = RATIO_W'(Q_ONE);
  localparam logic signed [RATIO_W-1:0] R_MONE = -R_ONE;

  mode_t                      mode;
  logic [BASE_W-1:0]          base;
  logic signed [RATIO_W-1:0]  ratio;
  gain_t                      fb_raw;
  gain_t                      wet_raw;

  logic signed [RATIO_W-1:0]  r_cl;
  logic signed [RATIO_W-1:0]  r_abs;
  gain_t                      mag;
  gain_t                      comp;
  gain_t                      frac_l;
  gain_t                      frac_r;
  logic [PW-1:0]              prod_l;
  logic [PW-1:0]              prod_r;
  logic [AW-1:0]              base_d;
  logic [AW-1:0]              sc_l;
  logic [AW-1:0]              sc_r;
  logic                       taps;
  logic                       neg;
  logic                       pos;

  function automatic logic [AW-1:0] clamp_d(input logic [31:0] d);
    if (d == 32'd0) begin
      return AW'(1);
    end else if (d > DMAX) begin
      return AW'(DMAX);
    end
    return AW'(d);
  endfunction

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode    <= MODE_NORMAL;
      base    <= BASE_W'(1);
      ratio   <= '0;
      fb_raw  <= '0;
      wet_raw <= WET_RESET;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg_idx_t'(cfg.index))
        CFG_MODE:  mode    <= mode_t'(cfg.data[1:0]);
        CFG_BASE:  base    <= cfg.data[BASE_W-1:0];
        CFG_RATIO: ratio   <= signed'(cfg.data[RATIO_W-1:0]);
        CFG_FB:    fb_raw  <= cfg.data[GAIN_W-1:0];
        CFG_WET:   wet_raw <= cfg.data[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    taps  = (mode == MODE_TAP) || (mode == MODE_TAP_FB);
    r_cl  = (ratio < R_MONE) ? R_MONE : ((ratio > R_ONE) ? R_ONE : ratio);
    neg   = r_cl < 0;
    pos   = r_cl > 0;
    r_abs = neg ? -r_cl : r_cl;
    mag   = r_abs[GAIN_W-1:0];
    comp  = GAIN_ONE - mag;
    if (taps) begin
      frac_l = neg ? mag : (pos ? comp : '0);
      frac_r = neg ? comp : (pos ? mag : '0);
    end else begin
      frac_l = neg ? mag : GAIN_ONE;
      frac_r = pos ? mag : GAIN_ONE;
    end
    prod_l = PW'(frac_l) * PW'(base);
    prod_r = PW'(frac_r) * PW'(base);
    sc_l   = clamp_d(32'(prod_l[PW-1:15]));
    sc_r   = clamp_d(32'(prod_r[PW-1:15]));
    base_d = clamp_d(32'(base));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      set     <= '{mode: MODE_NORMAL, fb: '0, wet: WET_RESET, dry: WET_RESET};
      dmain_l <= AW'(1);
      dmain_r <= AW'(1);
      dtap_l  <= AW'(1);
      dtap_r  <= AW'(1);
    end else begin
      set.mode <= mode;
      set.fb   <= clamp_gain(fb_raw);
      set.wet  <= clamp_gain(wet_raw);
      set.dry  <= GAIN_ONE - clamp_gain(wet_raw);
      dmain_l  <= taps ? base_d : sc_l;
      dmain_r  <= taps ? base_d : sc_r;
      dtap_l   <= sc_l;
      dtap_r   <= sc_r;
    end
  end

endmodule

// ===== rtl/sdly_lane.sv =====
// One channel lane: delay line memory, two reads per item, feedback and mix.
`timescale 1ns / 1ps
module sdly_lane #(
  parameter int LINE_DEPTH = 131072
) (
  input  logic                          clk,
  input  logic                          rst,
  input  sdly_pkg::sdly_set_t           set,
  input  logic [$clog2(LINE_DEPTH)-1:0] dmain,
  input  logic [$clog2(LINE_DEPTH)-1:0] dtap,
  input  sdly_pkg::sdly_item_t          item,
  input  logic [$clog2(LINE_DEPTH)-1:0] item_wp,
  input  sdly_pkg::sample_t             x_own,
  input  sdly_pkg::sample_t             x_other,
  input  sdly_pkg::sample_t             peer_main,
  output sdly_pkg::sample_t             main_val,
  output logic                          res_valid,
  output sdly_pkg::sample_t             res_sample
);
  import sdly_pkg::*;

  localparam int AW = $clog2(LINE_DEPTH);
  localparam logic signed [PROD_W:0]   FB_HALF  = (PROD_W + 1)'(1) <<< 15;
  localparam logic signed [PROD_W+1:0] MIX_HALF = (PROD_W + 2)'(1) <<< 14;

  sample_t line_mem [LINE_DEPTH];

  logic                 s0;
  logic                 s1;
  logic                 s2;
  logic                 s3;

  logic [AW-1:0]        c_wp;
  logic                 c_wrap;
  sample_t              c_xo;
  sample_t              c_xx;

  logic [AW-1:0]        rd_d;
  logic [AW:0]          rd_diff;
  logic [AW-1:0]        rd_addr;
  sample_t              rd_q;

  logic [AW-1:0]        s2_wp;
  logic                 s2_wrap;
  sample_t              s2_xo;
  sample_t              s2_xx;
  sample_t              main_q;

  logic                 main_ok;
  logic                 tap_ok;
  sample_t              tap_v;
  sample_t              tap_mix;
  sample_t              op1;
  sample_t              op2;
  logic signed [GAIN_W:0] fb_s;
  logic signed [GAIN_W:0] wet_s;
  logic signed [GAIN_W:0] dry_s;

  logic [AW-1:0]        s3_wp;
  sample_t              s3_x;
  prod_t                p1;
  prod_t                p2;
  prod_t                q0;
  prod_t                q1;
  prod_t                q2;

  logic signed [PROD_W:0]    fb_acc;
  logic signed [PROD_W-16:0] fb_t;
  logic signed [31:0]        line_pre;
  sample_t                   line_val;
  sample_t                   last_line;
  logic signed [PROD_W+1:0]  mix_acc;
  logic signed [PROD_W-14:0] mix_t;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0 <= 1'b0;
      s1 <= 1'b0;
      s2 <= 1'b0;
      s3 <= 1'b0;
    end else begin
      s0 <= item.take;
      s1 <= s0;
      s2 <= s1;
      s3 <= s2;
    end
  end

  always_ff @(posedge clk) begin
    if (item.take) begin
      c_wp   <= item_wp;
      c_wrap <= item.wrapped;
      c_xo   <= x_own;
      c_xx   <= x_other;
    end
  end

  // main tap read in the first cycle, second tap in the next
  always_comb begin
    rd_d    = s1 ? dtap : dmain;
    rd_diff = {1'b0, c_wp} - {1'b0, rd_d};
    rd_addr = rd_diff[AW] ? AW'(rd_diff + (AW + 1)'(LINE_DEPTH)) : rd_diff[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (s3) begin
      line_mem[s3_wp] <= line_val;
    end
    rd_q <= line_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (s1) begin
      s2_wp   <= c_wp;
      s2_wrap <= c_wrap;
      s2_xo   <= c_xo;
      s2_xx   <= c_xx;
      main_q  <= rd_q;
    end
  end

  // positions never written since reset read as zero; delay 1 bypasses the
  // previous item's write, which lands after this item's reads
  always_comb begin
    main_ok  = s2_wrap || (dmain <= s2_wp);
    tap_ok   = s2_wrap || (dtap <= s2_wp);
    main_val = !main_ok ? '0 : ((dmain == AW'(1)) ? last_line : main_q);
    tap_v    = !tap_ok ? '0 : ((dtap == AW'(1)) ? last_line : rd_q);
    tap_mix  = ((set.mode == MODE_TAP) || (set.mode == MODE_TAP_FB)) ? tap_v : '0;
    case (set.mode)
      MODE_TAP_FB: begin
        op1 = main_val;
        op2 = tap_v;
      end
      MODE_PONG: begin
        op1 = peer_main;
        op2 = peer_main;
      end
      default: begin
        op1 = main_val;
        op2 = main_val;
      end
    endcase
    fb_s  = signed'({1'b0, set.fb});
    wet_s = signed'({1'b0, set.wet});
    dry_s = signed'({1'b0, set.dry});
  end

  always_ff @(posedge clk) begin
    if (s2) begin
      p1    <= op1 * fb_s;
      p2    <= op2 * fb_s;
      q0    <= s2_xo * dry_s;
      q1    <= main_val * wet_s;
      q2    <= tap_mix * wet_s;
      s3_x  <= (set.mode == MODE_PONG) ? s2_xx : s2_xo;
      s3_wp <= s2_wp;
    end
  end

  always_comb begin
    fb_acc     = (PROD_W + 1)'(p1) + (PROD_W + 1)'(p2) + FB_HALF;
    fb_t       = fb_acc[PROD_W:16];
    line_pre   = 32'(s3_x) + 32'(fb_t);
    line_val   = sat_sample(line_pre);
    mix_acc    = (PROD_W + 2)'(q0) + (PROD_W + 2)'(q1) + (PROD_W + 2)'(q2) + MIX_HALF;
    mix_t      = mix_acc[PROD_W+1:15];
    res_sample = sat_sample(32'(mix_t));
    res_valid  = s3;
  end

  always_ff @(posedge clk) begin
    if (s3) begin
      last_line <= line_val;
    end
  end

endmodule

// ===== rtl/sdly_merge.sv =====
// Joins the lane results into output pairs and queues them for the sink.
`timescale 1ns / 1ps
module sdly_merge (
  input  logic              clk,
  input  logic              rst,
  input  logic              take,
  input  logic              push,
  input  sdly_pkg::sample_t left,
  input  sdly_pkg::sample_t right,
  output logic              room,
  sdly_out_if.source        out
);
  import sdly_pkg::*;

  localparam int PW = $clog2(OUT_DEPTH);
  localparam int CW = $clog2(OUT_DEPTH + 1);

  sample_t       q_left  [OUT_DEPTH];
  sample_t       q_right [OUT_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] fill;
  logic [CW-1:0] credit;
  logic          pop;

  assign pop           = out.valid && out.ready;
  assign out.valid     = fill != '0;
  assign out.left_out  = q_left[rd_ptr];
  assign out.right_out = q_right[rd_ptr];
  // credit covers items in flight plus queued ones, so the queue never overflows
  assign room          = credit != CW'(OUT_DEPTH);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
      credit <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      fill   <= fill + CW'(push) - CW'(pop);
      credit <= credit + CW'(take) - CW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_left[wr_ptr]  <= left;
      q_right[wr_ptr] <= right;
    end
  end

endmodule

// ===== rtl/sdly_checker.sv =====
// Port-level checks for the stereo delay effect, bound to the top level.
`timescale 1ns / 1ps
module sdly_props (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input sdly_pkg::sample_t left_out,
  input sdly_pkg::sample_t right_out
);
  import sdly_pkg::*;

  logic [3:0] outstanding;

  always_ff @(posedge clk) begin
    if (rst) begin
      outstanding <= '0;
    end else begin
      outstanding <= outstanding + 4'(in_valid && in_ready) - 4'(out_valid && out_ready);
    end
  end

  a_spacing: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken on consecutive cycles");

  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (outstanding != 4'd0))
    else $error("result offered with no item outstanding");

  a_bound: assert property (@(posedge clk) disable iff (rst)
    outstanding <= 4'(OUT_DEPTH))
    else $error("more items outstanding than the result queue holds");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(left_out) && $stable(right_out)))
    else $error("stalled result changed or dropped");

endmodule

bind stereo_delay_effect_top sdly_props u_sdly_props (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .left_out  (out_ch.left_out),
  .right_out (out_ch.right_out)
);

// ===== test/sdly_checker.sv =====
// Checker for the stereo delay effect: shadows registers and delay lines, predicts each mix.
`timescale 1ns / 1ps
module sdly_checker #(
  parameter int LINE_DEPTH = 131072
) (
  input  logic clk,
  input  logic rst,
  sdly_in_if   in_ch,
  sdly_out_if  out_ch,
  sdly_cfg_if  cfg,
  output int   errors,
  output int   outstanding
);
  import sdly_pkg::*;

  typedef struct {
    sample_t left;
    sample_t right;
  } mix_t;

  mode_t                     mode_q;
  logic [BASE_W-1:0]         base_q;
  logic signed [RATIO_W-1:0] ratio_q;
  gain_t                     fb_q;
  gain_t                     wet_q;

  sample_t     left_hist [LINE_DEPTH];
  sample_t     right_hist[LINE_DEPTH];
  int unsigned wr_pos;

  mix_t pending_mix[$];
  mix_t want;
  mix_t got;
  int   fail_cnt;

  function automatic longint clip_delay(longint d);
    if (d < 1) begin
      return 1;
    end
    if (d > LINE_DEPTH - 1) begin
      return LINE_DEPTH - 1;
    end
    return d;
  endfunction

  function automatic longint scaled_delay(longint frac);
    return clip_delay((frac * longint'(base_q)) >>> 15);
  endfunction

  function automatic longint round_q(longint v, int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic sample_t clip_sample(longint v);
    longint hi;
    longint lo;
    hi = (64'sd1 <<< (SAMPLE_BITS - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) begin
      v = hi;
    end else if (v < lo) begin
      v = lo;
    end
    return sample_t'(v);
  endfunction

  function automatic longint line_at(bit right_side, longint d);
    int unsigned idx;
    idx = int'((wr_pos + LINE_DEPTH - d) % LINE_DEPTH);
    if (right_side) begin
      return right_hist[idx];
    end
    return left_hist[idx];
  endfunction

  task automatic predict_mix(input sample_t xl_s, input sample_t xr_s, output mix_t res);
    longint xl, xr, r, fb, wet;
    longint dl, dr, tl, tr, ml, mr, al, ar, il, ir;
    bit     taps;
    xl = xl_s;
    xr = xr_s;
    r = ratio_q;
    if (r < -Q_ONE) r = -Q_ONE;
    if (r > Q_ONE) r = Q_ONE;
    fb = fb_q;
    if (fb > Q_ONE) fb = Q_ONE;
    wet = wet_q;
    if (wet > Q_ONE) wet = Q_ONE;
    taps = (mode_q == MODE_TAP) || (mode_q == MODE_TAP_FB);
    dl = clip_delay(longint'(base_q));
    dr = dl;
    tl = 1;
    tr = 1;
    if (taps) begin
      if (r < 0) begin
        tl = scaled_delay(-r);
        tr = scaled_delay(Q_ONE + r);
      end else if (r > 0) begin
        tl = scaled_delay(Q_ONE - r);
        tr = scaled_delay(r);
      end
    end else if (r < 0) begin
      dl = scaled_delay(-r);
    end else if (r > 0) begin
      dr = scaled_delay(r);
    end
    ml = line_at(1'b0, dl);
    mr = line_at(1'b1, dr);
    al = taps ? line_at(1'b0, tl) : 0;
    ar = taps ? line_at(1'b1, tr) : 0;
    case (mode_q)
      MODE_TAP_FB: begin
        il = xl + round_q((ml + al) * fb, 16);
        ir = xr + round_q((mr + ar) * fb, 16);
      end
      MODE_PONG: begin
        il = xr + round_q(mr * fb, 15);
        ir = xl + round_q(ml * fb, 15);
      end
      default: begin
        il = xl + round_q(ml * fb, 15);
        ir = xr + round_q(mr * fb, 15);
      end
    endcase
    left_hist[wr_pos] = clip_sample(il);
    right_hist[wr_pos] = clip_sample(ir);
    wr_pos = (wr_pos + 1) % LINE_DEPTH;
    res.left = clip_sample(round_q(xl * (Q_ONE - wet) + (ml + al) * wet, 15));
    res.right = clip_sample(round_q(xr * (Q_ONE - wet) + (mr + ar) * wet, 15));
  endtask

  task automatic note_mismatch(string field, sample_t exp_v, sample_t act_v);
    fail_cnt++;
    if (fail_cnt <= 10) begin
      $display("%0t: %s mismatch: expected %0d, got %0d", $realtime, field, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      mode_q = MODE_NORMAL;
      base_q = BASE_W'(1);
      ratio_q = '0;
      fb_q = '0;
      wet_q = WET_RESET;
      wr_pos = 0;
      for (int i = 0; i < LINE_DEPTH; i++) begin
        left_hist[i] = '0;
        right_hist[i] = '0;
      end
      pending_mix.delete();
      fail_cnt = 0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          CFG_MODE:  mode_q = mode_t'(cfg.data[1:0]);
          CFG_BASE:  base_q = cfg.data[BASE_W-1:0];
          CFG_RATIO: ratio_q = cfg.data[RATIO_W-1:0];
          CFG_FB:    fb_q = cfg.data[GAIN_W-1:0];
          CFG_WET:   wet_q = cfg.data[GAIN_W-1:0];
          default: ;
        endcase
      end
      if (out_ch.valid && out_ch.ready) begin
        got.left = out_ch.left_out;
        got.right = out_ch.right_out;
        if (pending_mix.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= 10) begin
            $display("%0t: result with none pending: left %0d right %0d",
                     $realtime, got.left, got.right);
          end
        end else begin
          want = pending_mix.pop_front();
          if (got.left !== want.left) note_mismatch("left_out", want.left, got.left);
          if (got.right !== want.right) note_mismatch("right_out", want.right, got.right);
        end
      end
      // each input transfer yields exactly one mixed pair
      if (in_ch.valid && in_ch.ready) begin
        predict_mix(in_ch.left_in, in_ch.right_in, want);
        pending_mix.push_back(want);
      end
    end
    errors <= fail_cnt;
    outstanding <= pending_mix.size();
  end

endmodule

// ===== test/tb_stereo_delay_effect_top.sv =====
// Testbench top for the stereo delay effect: clock, reset, stimulus, idling and verdict.
`timescale 1ns / 1ps
module tb_stereo_delay_effect_top;
  import sdly_pkg::*;

  localparam int LINE_DEPTH    = 131072;
  localparam int CYCLE_LIMIT   = 2_000_000;
  localparam int RANDOM_ITEMS  = 680;
  localparam int TAIL_ITEMS    = 100;
  localparam int SETTLE_CYCLES = 12;
  localparam sample_t S_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam sample_t S_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam logic [CFG_IDX_W-1:0] FIRST_SPARE_IDX = CFG_IDX_W'(CFG_WET + 1);

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   errors;
  int   outstanding;
  int   cycles = 0;
  int   hold_left = 0;
  int   items_sent = 0;
  int   regs_written = 0;
  int   pauses = 0;
  bit   gaps_on = 1'b0;
  bit   stall_on = 1'b0;

  sdly_in_if  in_ch ();
  sdly_out_if out_ch ();
  sdly_cfg_if cfg ();

  stereo_delay_effect_top #(.LINE_DEPTH(LINE_DEPTH)) u_top (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg    (cfg)
  );

  sdly_checker #(.LINE_DEPTH(LINE_DEPTH)) u_checker (
    .clk         (clk),
    .rst         (rst),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg         (cfg),
    .errors      (errors),
    .outstanding (outstanding)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, outstanding);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // receiver stalls in random bursts while stall_on is set
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else if (stall_on && $urandom_range(0, 5) == 0) begin
      hold_left <= $urandom_range(0, 4);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  function automatic sample_t pick_sample();
    case ($urandom_range(0, 7))
      0: return S_MAX;
      1: return S_MIN;
      2: return '0;
      3: return '1;
      default: return sample_t'($urandom);
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_base();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return CFG_DATA_W'($urandom);
      3: return CFG_DATA_W'($urandom_range(41, 2000));
      default: return CFG_DATA_W'($urandom_range(1, 40));
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_ratio();
    case ($urandom_range(0, 9))
      0: return 17'h10000;
      1: return 17'h0FFFF;
      2: return CFG_DATA_W'(Q_ONE);
      3: return CFG_DATA_W'(-Q_ONE);
      4: return '0;
      5: return CFG_DATA_W'($urandom);
      default: return CFG_DATA_W'(int'($urandom_range(0, 2 * Q_ONE)) - Q_ONE);
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_gain();
    gain_t g;
    case ($urandom_range(0, 5))
      0: g = '0;
      1: g = GAIN_ONE;
      2: g = '1;
      3: g = gain_t'($urandom);
      default: g = gain_t'($urandom_range(0, Q_ONE));
    endcase
    return {1'($urandom), g};
  endfunction

  task automatic send_pair(sample_t l, sample_t r);
    in_ch.valid <= 1'b1;
    in_ch.left_in <= l;
    in_ch.right_in <= r;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= val;
    do @(posedge clk); while (!cfg.ready);
    regs_written++;
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    cfg.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic load_regs(mode_t m, logic [CFG_DATA_W-1:0] base, logic [CFG_DATA_W-1:0] ratio,
                           logic [CFG_DATA_W-1:0] fb, logic [CFG_DATA_W-1:0] wet);
    logic [CFG_DATA_W-1:0] md;
    md = CFG_DATA_W'($urandom);
    md[1:0] = m;
    write_reg(CFG_MODE, md);
    write_reg(CFG_BASE, base);
    write_reg(CFG_RATIO, ratio);
    write_reg(CFG_FB, fb);
    write_reg(CFG_WET, wet);
    cfg.valid <= 1'b0;
  endtask

  task automatic shuffle_regs();
    logic [CFG_DATA_W-1:0] md;
    md = CFG_DATA_W'($urandom);
    md[1:0] = mode_t'($urandom_range(0, 3));
    if ($urandom_range(0, 1)) write_reg(CFG_MODE, md);
    if ($urandom_range(0, 1)) write_reg(CFG_BASE, pick_base());
    if ($urandom_range(0, 1)) write_reg(CFG_RATIO, pick_ratio());
    if ($urandom_range(0, 1)) write_reg(CFG_FB, pick_gain());
    if ($urandom_range(0, 1)) write_reg(CFG_WET, pick_gain());
    if ($urandom_range(0, 3) == 0) begin
      write_reg(CFG_IDX_W'($urandom_range(FIRST_SPARE_IDX, 2 ** CFG_IDX_W - 1)),
                CFG_DATA_W'($urandom));
    end
    cfg.valid <= 1'b0;
  endtask

  task automatic saturating_burst();
    send_pair(S_MAX, S_MAX);
    send_pair(S_MIN, S_MAX);
    send_pair(S_MAX, S_MIN);
    send_pair('0, S_MIN);
  endtask

  initial begin
    int phase;
    int n;
    int pause_at;
    int leftover;
    in_ch.valid = 1'b0;
    in_ch.left_in = '0;
    in_ch.right_in = '0;
    cfg.valid = 1'b0;
    cfg.index = '0;
    cfg.data = '0;
    out_ch.ready = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // defaults after reset
    send_pair(S_MAX, S_MIN);
    send_pair(S_MIN, S_MAX);
    send_pair('0, '1);

    // one pass per mode, each with an out-of-range or degenerate setting
    drain();
    load_regs(MODE_NORMAL, 17'd2, 17'h0FFFF, CFG_DATA_W'(Q_ONE), CFG_DATA_W'(Q_ONE));
    saturating_burst();
    drain();
    load_regs(MODE_TAP, 17'd3, 17'h10000, 17'h0FFFF, '0);
    saturating_burst();
    drain();
    load_regs(MODE_TAP_FB, 17'd4, '0, CFG_DATA_W'(Q_ONE), 17'h1FFFF);
    saturating_burst();
    drain();
    load_regs(MODE_PONG, '0, CFG_DATA_W'(-16384), CFG_DATA_W'(Q_ONE), CFG_DATA_W'(Q_ONE / 2));
    saturating_burst();

    phase = 0;
    while (items_sent < 19 + RANDOM_ITEMS) begin
      drain();
      shuffle_regs();
      gaps_on = $urandom_range(0, 3) != 0;
      stall_on = $urandom_range(0, 3) != 0;
      n = $urandom_range(10, 60);
      pause_at = (phase == 0 || $urandom_range(0, 3) == 0) ? $urandom_range(1, n - 1) : -1;
      for (int i = 0; i < n; i++) begin
        if (i == pause_at) begin
          drain();
          pauses++;
        end
        send_pair(pick_sample(), pick_sample());
      end
      phase++;
    end

    // back-to-back stream with feedback and no idling on either side
    drain();
    gaps_on = 1'b0;
    stall_on = 1'b0;
    load_regs(MODE_TAP_FB, 17'd37, CFG_DATA_W'(-12000), CFG_DATA_W'(24576),
              CFG_DATA_W'(20000));
    for (int i = 0; i < TAIL_ITEMS; i++) begin
      send_pair(pick_sample(), pick_sample());
    end

    in_ch.valid <= 1'b0;
    @(posedge clk);
    for (int k = 0; k < 1000 && outstanding != 0; k++) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    leftover = outstanding;
    if (leftover != 0) begin
      $display("%0d expected results never arrived", leftover);
    end

    $display("Ran %0d sample pairs in %0d random phases over all four modes, %0d register writes,",
             items_sent, phase, regs_written);
    $display("%0d drain pauses and a closing stream of %0d pairs with no idling; %0d mismatches.",
             pauses, TAIL_ITEMS, errors);
    if (errors == 0 && leftover == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
